/* sv/assert_macros.svh */
// Assertion shorthands shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property while out of reset.
`define RDMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included.
`define RDMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/rdmc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdmc_pkg
// Shared types and codes of the maze carver: ops, square codes, register
// indexes, stack entry and the controller/datapath interface.
// ----------------------------------------------------------------------------
package rdmc_pkg;

  localparam int CRD_W      = 7;
  localparam int COUNT_W    = 11;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  typedef logic [CRD_W-1:0] crd_t;

  typedef enum logic [1:0] {
    OP_RESTART = 2'd0,
    OP_STEP    = 2'd1,
    OP_READ    = 2'd2,
    OP_NOP     = 2'd3
  } op_t;

  localparam logic [1:0] SQ_WALL = 2'd0;
  localparam logic [1:0] SQ_ROAD = 2'd1;
  localparam logic [1:0] SQ_EXIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_COL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXIT_ROW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_GOAL   = 3'd4;

  typedef struct packed {
    crd_t col;
    crd_t row;
    crd_t pcol;
    crd_t prow;
  } entry_t;

  typedef enum logic [4:0] {
    ST_RST_CLR, ST_IDLE, ST_DISP, ST_CLR, ST_EXIT, ST_POP, ST_POPW,
    ST_CELL, ST_CELLW, ST_MID, ST_MIDW, ST_NB, ST_NBW, ST_SHUF, ST_PUSH,
    ST_SQRD, ST_SQW, ST_DONE
  } st_t;

  typedef struct packed {
    logic load_in;
    logic clr_write;
    logic exit_init;
    logic pop_rd;
    logic pop_latch;
    logic cell_rd;
    logic cell_eval;
    logic mid_rd;
    logic mid_eval;
    logic nb_rd;
    logic nb_eval;
    logic shuffle;
    logic push;
    logic sq_rd;
    logic sq_latch;
    logic idx_clr;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    op_t  op;
    logic finished;
    logic cell_road;
    logic idx_last;
    logic rd_inb;
  } sts_t;

endpackage

/* sv/randomized_dfs_maze_carver.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// randomized_dfs_maze_carver
// Recursive-backtracker maze carver with a square read-back port.
// ----------------------------------------------------------------------------
// Usage: write the size, exit and goal registers on the cfg_ port while idle,
// then send transactions on the in_ channel (valid/ready). Op 0 restarts the
// maze, op 1 runs one carve step with the caller's shuffle picks, op 2 reads
// one square. Every transaction gives exactly one result on the out_ channel.
// Steps from accept to result valid:
//   carve step: stack pop, cell, midpoint and four neighbour board reads,
//     a shuffle, then four push slots, one memory access each; when
//     already finished it goes straight to the result, and on a duplicate
//     pop it ends after the cell read.
//   read: one board read, none outside the grid; op 3: straight to the result.
//   restart: the board clearing sweep of one square per cycle, then the
//     exit square and first stack entry are written if inside the grid.
// One transaction is in work at a time; the next is accepted in the cycle
// after the result is loaded. After reset the block runs the same clearing
// sweep with in_ready low; configuration writes are taken throughout.
// A result waits in the output register while out_ready is low; the next
// transaction is still accepted and runs up to its own result, then holds.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module randomized_dfs_maze_carver import rdmc_pkg::*; #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_HEIGHT  = 64,
  parameter int STACK_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_op,
  input  logic [1:0]            in_pick_of_four,
  input  logic [1:0]            in_pick_of_three,
  input  logic                  in_pick_of_two,
  input  logic [5:0]            in_read_col,
  input  logic [5:0]            in_read_row,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_square,
  output logic                  out_finished,
  output logic                  out_carved_new,
  output logic [COUNT_W-1:0]    out_cells_carved
);

  cmd_t cmd;
  sts_t sts;

  // sequencer: owns both handshakes and walks the step sequence
  rdmc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: registers, board and frontier stack
  rdmc_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_op           (in_op),
    .in_pick_of_four (in_pick_of_four),
    .in_pick_of_three(in_pick_of_three),
    .in_pick_of_two  (in_pick_of_two),
    .in_read_col     (in_read_col),
    .in_read_row     (in_read_row),
    .cmd             (cmd),
    .sts             (sts),
    .out_square      (out_square),
    .out_finished    (out_finished),
    .out_carved_new  (out_carved_new),
    .out_cells_carved(out_cells_carved)
  );

  // a pop only ever happens with entries on the stack
  `RDMC_ASSERT(a_pop_not_done, cmd.pop_rd |-> !sts.finished, "pop while finished")
  // a freshly carved cell means the count is nonzero
  `RDMC_ASSERT(a_carve_counts, out_valid && out_carved_new |-> out_cells_carved != '0,
    "carved flag with zero count")
  // a transaction drops ready for at least the next cycle
  `RDMC_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready,
    "ready held after accept")
  // the clearing sweep never overlaps acceptance
  `RDMC_ASSERT_ALWAYS(a_clear_busy, cmd.clr_write |-> !in_ready, "ready during clear")

endmodule

/* sv/rdmc_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdmc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rdmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/rdmc_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdmc_ctrl
// Sequencer: handshakes, op dispatch and the step sequence of the carver.
// ----------------------------------------------------------------------------
module rdmc_ctrl import rdmc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  st_t  state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      ST_RST_CLR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = ST_DISP;
        end
      end
      ST_DISP: begin
        cmd.idx_clr = 1'b1;
        case (sts.op)
          OP_RESTART: state_nxt = ST_CLR;
          OP_STEP:    state_nxt = sts.finished ? ST_DONE : ST_POP;
          OP_READ:    state_nxt = sts.rd_inb ? ST_SQRD : ST_DONE;
          default:    state_nxt = ST_DONE;
        endcase
      end
      ST_CLR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) state_nxt = ST_EXIT;
      end
      ST_EXIT: begin
        cmd.exit_init = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_POP: begin
        cmd.pop_rd = 1'b1;
        state_nxt  = ST_POPW;
      end
      ST_POPW: begin
        cmd.pop_latch = 1'b1;
        state_nxt     = ST_CELL;
      end
      ST_CELL: begin
        cmd.cell_rd = 1'b1;
        state_nxt   = ST_CELLW;
      end
      ST_CELLW: begin
        cmd.cell_eval = 1'b1;
        state_nxt     = sts.cell_road ? ST_DONE : ST_MID;
      end
      ST_MID: begin
        cmd.mid_rd = 1'b1;
        state_nxt  = ST_MIDW;
      end
      ST_MIDW: begin
        cmd.mid_eval = 1'b1;
        state_nxt    = ST_NB;
      end
      ST_NB: begin
        cmd.nb_rd = 1'b1;
        state_nxt = ST_NBW;
      end
      ST_NBW: begin
        cmd.nb_eval = 1'b1;
        state_nxt   = sts.idx_last ? ST_SHUF : ST_NB;
      end
      ST_SHUF: begin
        cmd.shuffle = 1'b1;
        state_nxt   = ST_PUSH;
      end
      ST_PUSH: begin
        cmd.push = 1'b1;
        if (sts.idx_last) state_nxt = ST_DONE;
      end
      ST_SQRD: begin
        cmd.sq_rd = 1'b1;
        state_nxt = ST_SQW;
      end
      ST_SQW: begin
        cmd.sq_latch = 1'b1;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

/* sv/rdmc_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdmc_dp
// Datapath: registers, board and stack memories, neighbour and shuffle logic.
// ----------------------------------------------------------------------------
module rdmc_dp import rdmc_pkg::*; #(
  parameter int MAX_WIDTH   = 64,
  parameter int MAX_HEIGHT  = 64,
  parameter int STACK_DEPTH = 4096
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [1:0]            in_op,
  input  logic [1:0]            in_pick_of_four,
  input  logic [1:0]            in_pick_of_three,
  input  logic                  in_pick_of_two,
  input  logic [5:0]            in_read_col,
  input  logic [5:0]            in_read_row,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  output logic [1:0]            out_square,
  output logic                  out_finished,
  output logic                  out_carved_new,
  output logic [COUNT_W-1:0]    out_cells_carved
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int AW  = CW + RW;
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int FW  = $clog2(STACK_DEPTH + 1);
  localparam int EW  = $bits(entry_t);

  function automatic logic [AW-1:0] sq_addr(input crd_t c, input crd_t r);
    logic [CW+CRD_W-1:0] ce;
    logic [RW+CRD_W-1:0] re;
    ce = {{CW{1'b0}}, c};
    re = {{RW{1'b0}}, r};
    return {re[RW-1:0], ce[CW-1:0]};
  endfunction

  // configuration
  logic [6:0]         gw_r, gh_r;
  logic [5:0]         ec_r, er_r;
  logic [COUNT_W-1:0] goal_r;
  crd_t               eff_w, eff_h, exit_c, exit_r;
  logic               exit_inb;

  // control counters
  logic [FW-1:0]      fill_r;
  logic [COUNT_W-1:0] count_r;
  logic [AW-1:0]      clr_r;
  logic [1:0]         idx_r;

  // payload
  op_t                op_r;
  logic [1:0]         p4_r, p3_r;
  logic               p2_r;
  logic [5:0]         rc_r, rr_r;
  entry_t             ent_r;
  logic [3:0]         nv_r;
  logic [3:0][1:0]    perm_r, perm_nxt;
  logic               carved_r;
  logic [1:0]         square_r;
  logic [1:0]         out_square_r;
  logic               out_finished_r, out_carved_r;
  logic [COUNT_W-1:0] out_count_r;

  // memories
  logic               b_we;
  logic [AW-1:0]      b_waddr, b_raddr;
  logic [1:0]         b_wdata, b_rdata;
  logic               s_we;
  logic [SIW-1:0]     s_waddr, s_raddr;
  entry_t             s_wdata;
  logic [EW-1:0]      s_rdata;

  logic [1:0]         dir;
  logic [CRD_W:0]     c8, r8, nbc8, nbr8, mc8, mr8;
  crd_t               nbc, nbr, mc, mr;
  logic               nb_inb, rd_inb, finished, fresh, push_ok;
  logic [FW-1:0]      fill_m1;
  logic [1:0]         p3c, tmp;

  assign eff_w  = ({2'b0, gw_r} > 9'(MAX_WIDTH))  ? 7'(MAX_WIDTH)  : gw_r;
  assign eff_h  = ({2'b0, gh_r} > 9'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : gh_r;
  assign exit_c = {1'b0, ec_r};
  assign exit_r = {1'b0, er_r};
  assign exit_inb = (exit_c < eff_w) && (exit_r < eff_h);
  assign rd_inb   = ({1'b0, rc_r} < eff_w) && ({1'b0, rr_r} < eff_h);
  assign finished = (count_r >= goal_r) || (fill_r == '0);
  assign fresh    = (b_rdata == SQ_WALL);
  assign fill_m1  = fill_r - 1'b1;

  // neighbour of the current direction
  assign dir = cmd.push ? perm_r[idx_r] : idx_r;
  assign c8  = {1'b0, ent_r.col};
  assign r8  = {1'b0, ent_r.row};
  always_comb begin
    nbc8   = c8;
    nbr8   = r8;
    nb_inb = 1'b0;
    case (dir)
      2'd0: begin
        nbr8   = r8 + 8'd2;
        nb_inb = nbr8 < {1'b0, eff_h};
      end
      2'd1: begin
        nbr8   = r8 - 8'd2;
        nb_inb = ent_r.row >= 7'd2;
      end
      2'd2: begin
        nbc8   = c8 + 8'd2;
        nb_inb = nbc8 < {1'b0, eff_w};
      end
      default: begin
        nbc8   = c8 - 8'd2;
        nb_inb = ent_r.col >= 7'd2;
      end
    endcase
  end
  assign nbc = nbc8[CRD_W-1:0];
  assign nbr = nbr8[CRD_W-1:0];

  assign mc8 = c8 + {1'b0, ent_r.pcol};
  assign mr8 = r8 + {1'b0, ent_r.prow};
  assign mc  = mc8[CRD_W:1];
  assign mr  = mr8[CRD_W:1];

  // Fisher-Yates over the four slots
  always_comb begin
    perm_nxt = {2'd3, 2'd2, 2'd1, 2'd0};
    p3c      = (p3_r == 2'd3) ? 2'd2 : p3_r;
    tmp           = perm_nxt[3];
    perm_nxt[3]   = perm_nxt[p4_r];
    perm_nxt[p4_r] = tmp;
    tmp           = perm_nxt[2];
    perm_nxt[2]   = perm_nxt[p3c];
    perm_nxt[p3c] = tmp;
    tmp           = perm_nxt[1];
    perm_nxt[1]   = perm_nxt[{1'b0, p2_r}];
    perm_nxt[{1'b0, p2_r}] = tmp;
  end

  // board ports
  always_comb begin
    b_we    = 1'b0;
    b_waddr = clr_r;
    b_wdata = SQ_WALL;
    if (cmd.clr_write) begin
      b_we = 1'b1;
    end else if (cmd.exit_init && exit_inb) begin
      b_we    = 1'b1;
      b_waddr = sq_addr(exit_c, exit_r);
      b_wdata = SQ_EXIT;
    end else if (cmd.cell_eval && fresh) begin
      b_we    = 1'b1;
      b_waddr = sq_addr(ent_r.col, ent_r.row);
      b_wdata = SQ_ROAD;
    end else if (cmd.mid_eval && fresh) begin
      b_we    = 1'b1;
      b_waddr = sq_addr(mc, mr);
      b_wdata = SQ_ROAD;
    end
  end

  always_comb begin
    if (cmd.cell_rd) begin
      b_raddr = sq_addr(ent_r.col, ent_r.row);
    end else if (cmd.mid_rd) begin
      b_raddr = sq_addr(mc, mr);
    end else if (cmd.nb_rd) begin
      b_raddr = sq_addr(nbc, nbr);
    end else if (cmd.sq_rd) begin
      b_raddr = sq_addr({1'b0, rc_r}, {1'b0, rr_r});
    end else begin
      b_raddr = clr_r;
    end
  end

  // stack ports
  assign push_ok = cmd.push && nv_r[dir] && (fill_r != FW'(STACK_DEPTH));
  assign s_we    = (cmd.exit_init && exit_inb) || push_ok;
  assign s_waddr = cmd.exit_init ? '0 : fill_r[SIW-1:0];
  assign s_wdata = cmd.exit_init ? entry_t'{exit_c, exit_r, exit_c, exit_r}
                                 : entry_t'{nbc, nbr, ent_r.col, ent_r.row};
  assign s_raddr = fill_m1[SIW-1:0];

  rdmc_ram #(.WIDTH(2), .DEPTH(1 << AW)) u_board (
    .clk  (clk),
    .we   (b_we),
    .waddr(b_waddr),
    .wdata(b_wdata),
    .raddr(b_raddr),
    .rdata(b_rdata)
  );

  rdmc_ram #(.WIDTH(EW), .DEPTH(STACK_DEPTH)) u_stack (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r    <= 7'd64;
      gh_r    <= 7'd64;
      ec_r    <= '0;
      er_r    <= '0;
      goal_r  <= 11'd1024;
      fill_r  <= '0;
      count_r <= '0;
      clr_r   <= '0;
      idx_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GRID_WIDTH:  gw_r   <= cfg_wdata[6:0];
          CFG_GRID_HEIGHT: gh_r   <= cfg_wdata[6:0];
          CFG_EXIT_COL:    ec_r   <= cfg_wdata[5:0];
          CFG_EXIT_ROW:    er_r   <= cfg_wdata[5:0];
          CFG_CELL_GOAL:   goal_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.clr_write) clr_r <= clr_r + 1'b1;
      if (cmd.exit_init) begin
        fill_r  <= exit_inb ? FW'(1) : '0;
        count_r <= exit_inb ? COUNT_W'(1) : '0;
      end
      if (cmd.pop_rd) fill_r <= fill_m1;
      if (push_ok) fill_r <= fill_r + 1'b1;
      if (cmd.cell_eval && fresh && (count_r != '1)) count_r <= count_r + 1'b1;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.nb_eval || cmd.push) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r     <= op_t'(in_op);
      p4_r     <= in_pick_of_four;
      p3_r     <= in_pick_of_three;
      p2_r     <= in_pick_of_two;
      rc_r     <= in_read_col;
      rr_r     <= in_read_row;
      carved_r <= 1'b0;
      square_r <= SQ_WALL;
    end
    if (cmd.pop_latch) ent_r <= entry_t'(s_rdata);
    if (cmd.cell_eval && fresh) carved_r <= 1'b1;
    if (cmd.nb_eval) nv_r[idx_r] <= nb_inb && fresh;
    if (cmd.shuffle) perm_r <= perm_nxt;
    if (cmd.sq_latch) square_r <= b_rdata;
    if (cmd.out_load) begin
      out_square_r   <= square_r;
      out_finished_r <= finished;
      out_carved_r   <= carved_r;
      out_count_r    <= count_r;
    end
  end

  assign sts.clr_last  = &clr_r;
  assign sts.op        = op_r;
  assign sts.finished  = finished;
  assign sts.cell_road = (b_rdata == SQ_ROAD);
  assign sts.idx_last  = (idx_r == 2'd3);
  assign sts.rd_inb    = rd_inb;

  assign out_square       = out_square_r;
  assign out_finished     = out_finished_r;
  assign out_carved_new   = out_carved_r;
  assign out_cells_carved = out_count_r;

endmodule
